/* rtl/core/wssf_pkg.sv */
// ----------------------------------------------------------------------------
// wssf_pkg
// Shared constants, register indexes and character helpers of the word
// substring and subsequence filter.
// ----------------------------------------------------------------------------
package wssf_pkg;

  localparam int PatternMaxDefault = 16;
  localparam int PatLenW           = 5;
  localparam int CfgIndexW         = 3;
  localparam int CfgDataW          = 64;
  localparam int CharW             = 8;
  localparam int IndexW            = 16;
  localparam int LengthW           = 8;
  localparam int OutDataW          = IndexW + LengthW;

  localparam logic [CfgIndexW-1:0] CfgEnable      = 3'd0;
  localparam logic [CfgIndexW-1:0] CfgMode        = 3'd1;
  localparam logic [CfgIndexW-1:0] CfgPatternLen  = 3'd2;
  localparam logic [CfgIndexW-1:0] CfgPatternLow  = 3'd3;
  localparam logic [CfgIndexW-1:0] CfgPatternHigh = 3'd4;

  localparam logic [LengthW-1:0] LengthSat = 8'd255;

  // Upper case ASCII letters become lower case; every other byte is kept.
  function automatic logic [CharW-1:0] fold_char(input logic [CharW-1:0] c);
    logic [CharW-1:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  // Horizontal tab through carriage return, and the space character.
  function automatic logic is_space(input logic [CharW-1:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

/* rtl/core/wssf_cell.sv */
// ----------------------------------------------------------------------------
// wssf_cell
// One pattern position: holds the shift-and prefix bit and the greedy
// subsequence bit of its character and hands both to the next cell.
// ----------------------------------------------------------------------------
module wssf_cell (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       clear,
  input  logic [7:0] text_char,
  input  logic [7:0] pat_char,
  input  logic       active,
  input  logic       prefix_in,
  input  logic       done_in,
  output logic       prefix,
  output logic       done,
  output logic       prefix_step,
  output logic       done_step
);

  logic match;

  assign match       = active && (text_char == pat_char);
  // The pattern up to this character ends at the current byte.
  assign prefix_step = prefix_in & match;
  // The previous character is already consumed, so this one may be taken.
  assign done_step   = done | (done_in & match);

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      prefix <= 1'b0;
      done   <= 1'b0;
    end else if (step) begin
      prefix <= prefix_step;
      done   <= done_step;
    end
  end

endmodule

/* rtl/core/word_substring_subsequence_filter_unit.sv */
// ----------------------------------------------------------------------------
// word_substring_subsequence_filter_unit
// Splits a text byte stream into words and reports every word that holds the
// pattern as a substring or as a subsequence.
// ----------------------------------------------------------------------------
// Usage: text bytes enter on the s_ stream, one byte per transaction, with
// s_tlast marking the final byte of the text. Whitespace bytes separate
// words; letters are compared without regard to case. For every closed word
// that matches, one transaction leaves on the m_ stream carrying the word's
// ordinal since reset and its length, saturated at 255.
// Throughput is one byte per cycle while the m_ stream is not stalled. Each
// pattern position is one cell of a chain, and each byte updates all cells in
// the cycle it is accepted, so the only loop is the cell update.
// The result of an accepted closing byte is on m_tvalid in the next cycle,
// from the output register.
// The output register lets a new byte enter in the same cycle as a waiting
// result is taken; while the receiver holds m_tready low with a result
// pending, s_tready is low and no byte is taken.
// Configuration registers are written through cfg_we/cfg_index/cfg_data and
// act from the next byte. Reset clears the configuration registers, the word
// state, the word counter and the output valid; with enable low, bytes are
// consumed and dropped without touching any state.
// ----------------------------------------------------------------------------
module word_substring_subsequence_filter_unit
  import wssf_pkg::*;
#(
  parameter int PATTERN_MAX = PatternMaxDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CfgIndexW-1:0] cfg_index,
  input  logic [CfgDataW-1:0]  cfg_data,
  // Text input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [CharW-1:0]     s_tdata,   // [7:0] text_byte
  input  logic                 s_tlast,   // end_of_text
  // Result stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OutDataW-1:0]  m_tdata    // [15:0] word_index, [23:16] word_length
);

  // Configuration registers.
  logic               enable;
  logic               mode;
  logic [PatLenW-1:0] pattern_length;
  logic [CfgDataW-1:0] pattern_low;
  logic [CfgDataW-1:0] pattern_high;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      mode           <= 1'b0;
      pattern_length <= '0;
      pattern_low    <= '0;
      pattern_high   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CfgEnable:      enable         <= cfg_data[0];
        CfgMode:        mode           <= cfg_data[0];
        CfgPatternLen:  pattern_length <= cfg_data[PatLenW-1:0];
        CfgPatternLow:  pattern_low    <= cfg_data;
        CfgPatternHigh: pattern_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pattern lengths beyond the number of cells act as a full pattern.
  logic [PatLenW-1:0] pat_len;
  logic               pat_empty;

  assign pat_len   = (pattern_length > PatLenW'(PATTERN_MAX)) ?
                     PatLenW'(PATTERN_MAX) : pattern_length;
  assign pat_empty = (pat_len == '0);

  // Word state.
  logic               word_found;
  logic               inside_word;
  logic [LengthW-1:0] current_length;
  logic [IndexW-1:0]  word_counter;

  // Byte classification and the handshake.
  logic             take;
  logic             space;
  logic             step;
  logic             close;
  logic [CharW-1:0] text_char;

  assign s_tready  = !m_tvalid || m_tready;
  assign take      = s_tvalid && s_tready && enable;
  assign space     = is_space(s_tdata);
  assign text_char = fold_char(s_tdata);
  assign step      = take && !space;
  // A whitespace byte closes an open word; a word byte with end of text
  // is first added and then closes the word.
  assign close     = take && ((space && inside_word) || (!space && s_tlast));

  // Chain of pattern cells.
  logic [2*CfgDataW-1:0]  pat_all;
  logic [PATTERN_MAX-1:0] prefix;
  logic [PATTERN_MAX-1:0] done;
  logic [PATTERN_MAX-1:0] prefix_step;
  logic [PATTERN_MAX-1:0] done_step;
  logic [PATTERN_MAX-1:0] last_mask;

  assign pat_all = {pattern_high, pattern_low};

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
    localparam logic [PatLenW-1:0] CellPos  = PatLenW'(i);
    localparam logic [PatLenW-1:0] CellNext = PatLenW'(i + 1);

    logic prefix_prev;
    logic done_prev;

    if (i == 0) begin : g_head
      assign prefix_prev = 1'b1;
      assign done_prev   = 1'b1;
    end else begin : g_link
      assign prefix_prev = prefix[i-1];
      assign done_prev   = done[i-1];
    end

    // Marks the cell of the last pattern character in use.
    assign last_mask[i] = (pat_len == CellNext);

    wssf_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .step        (step),
      .clear       (close),
      .text_char   (text_char),
      .pat_char    (fold_char(pat_all[CharW*i +: CharW])),
      .active      (CellPos < pat_len),
      .prefix_in   (prefix_prev),
      .done_in     (done_prev),
      .prefix      (prefix[i]),
      .done        (done[i]),
      .prefix_step (prefix_step[i]),
      .done_step   (done_step[i])
    );
  end

  // Match status including the byte now being accepted.
  logic               sub_hit;
  logic               seq_hit;
  logic               found_next;
  logic               result_match;
  logic [LengthW-1:0] length_next;
  logic [LengthW-1:0] result_length;

  assign sub_hit      = |(prefix_step & last_mask);
  assign seq_hit      = |(done_step & last_mask);
  assign found_next   = word_found || pat_empty || (mode ? seq_hit : sub_hit);
  assign result_match = space ? (word_found || pat_empty) : found_next;
  assign length_next  = (current_length == LengthSat) ? current_length :
                        current_length + LengthW'(1);
  assign result_length = space ? current_length : length_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_found     <= 1'b0;
      inside_word    <= 1'b0;
      current_length <= '0;
      word_counter   <= '0;
    end else if (close) begin
      word_found     <= 1'b0;
      inside_word    <= 1'b0;
      current_length <= '0;
      word_counter   <= word_counter + IndexW'(1);
    end else if (step) begin
      word_found     <= found_next;
      inside_word    <= 1'b1;
      current_length <= length_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= close && result_match;
    end
  end

  always_ff @(posedge clk) begin
    if (close && result_match) begin
      m_tdata <= {result_length, word_counter};
    end
  end

endmodule

/* test/word_substring_subsequence_filter_unit_test.sv */
// ----------------------------------------------------------------------------
// word_substring_subsequence_filter_unit_test
// Self-checking testbench of the word substring and subsequence filter. Text
// bytes are streamed in while a scoreboard predicts which words match and
// checks every result transaction, under several register settings and
// flow-control patterns.
// ----------------------------------------------------------------------------
module word_substring_subsequence_filter_unit_test;
  import wssf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transaction before the run is declared hung. The
  // longest legal quiet stretch is the receiver hold-off below.
  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 300;

  typedef struct packed {
    bit [IndexW-1:0]  index;
    bit [LengthW-1:0] length;
  } word_result_t;

  // Scoreboard: keeps its own copy of the registers and of the word state,
  // predicts the result of every accepted text byte and checks the results
  // leaving the block in order.
  class word_match_model;
    bit                         enable;
    bit                         mode;
    bit [PatLenW-1:0]           length_reg;
    bit [CfgDataW-1:0]          pattern_low;
    bit [CfgDataW-1:0]          pattern_high;
    bit [PatternMaxDefault-1:0] prefix_bits;
    bit [PatLenW-1:0]           progress;
    bit                         found;
    bit                         in_word;
    bit [LengthW-1:0]           cur_length;
    bit [IndexW-1:0]            word_count;
    word_result_t               expected_words[$];
    int                         errors;

    function void set_register(logic [CfgIndexW-1:0] idx, logic [CfgDataW-1:0] value);
      case (idx)
        CfgEnable:      enable = value[0];
        CfgMode:        mode = value[0];
        CfgPatternLen:  length_reg = value[PatLenW-1:0];
        CfgPatternLow:  pattern_low = value;
        CfgPatternHigh: pattern_high = value;
        default: ;
      endcase
    endfunction

    function bit [7:0] to_lower(bit [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function int active_len();
      return (length_reg > PatternMaxDefault) ? PatternMaxDefault : int'(length_reg);
    endfunction

    function bit [7:0] pattern_char(int i);
      bit [CfgDataW-1:0] src;
      src = (i < 8) ? pattern_low : pattern_high;
      return to_lower(src[(i % 8) * 8 +: 8]);
    endfunction

    // Notes one accepted text transaction and queues the result it causes.
    function void absorb_byte(bit [7:0] b, bit eot);
      int                         m;
      bit                         close;
      bit [PatternMaxDefault-1:0] hits;
      bit [7:0]                   lc;
      word_result_t               r;
      m = active_len();
      close = 1'b0;
      hits = '0;
      if (!enable) begin
        return;
      end
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
        close = in_word;
      end else begin
        lc = to_lower(b);
        for (int i = 0; i < m; i++) begin
          if (pattern_char(i) == lc) begin
            hits[i] = 1'b1;
          end
        end
        prefix_bits = ((prefix_bits << 1) | 1) & hits;
        if (progress < m && pattern_char(progress) == lc) begin
          progress++;
        end
        if (m == 0) begin
          found = 1'b1;
        end else if (mode) begin
          if (progress >= m) begin
            found = 1'b1;
          end
        end else if (prefix_bits[m-1]) begin
          found = 1'b1;
        end
        in_word = 1'b1;
        if (cur_length != LengthSat) begin
          cur_length++;
        end
        if (eot) begin
          close = 1'b1;
        end
      end
      if (close) begin
        if (found || m == 0) begin
          r.index = word_count;
          r.length = cur_length;
          expected_words.push_back(r);
        end
        word_count++;
        prefix_bits = '0;
        progress = '0;
        found = 1'b0;
        in_word = 1'b0;
        cur_length = '0;
      end
    endfunction

    // Checks one result transaction against the oldest prediction.
    function void check_result(bit [IndexW-1:0] idx, bit [LengthW-1:0] len);
      word_result_t want;
      if (expected_words.size() == 0) begin
        errors++;
        $display("%t: unexpected result, word_index %0d word_length %0d", $time, idx, len);
        return;
      end
      want = expected_words.pop_front();
      if (want.index != idx) begin
        errors++;
        $display("%t: word_index expected %0d got %0d", $time, want.index, idx);
      end
      if (want.length != len) begin
        errors++;
        $display("%t: word_length expected %0d got %0d", $time, want.length, len);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIndexW-1:0] cfg_index;
  logic [CfgDataW-1:0]  cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [CharW-1:0]     s_tdata;   // [7:0] text_byte
  logic                 s_tlast;   // end_of_text
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutDataW-1:0]  m_tdata;   // [15:0] word_index, [23:16] word_length

  word_match_model model = new();

  int   sender_idle_pct = 0;
  int   stall_pct = 0;
  int   sent_bytes = 0;
  int   quiet_cycles = 0;
  logic hold_req;

  word_substring_subsequence_filter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver. Normally m_tready is drawn at random every cycle. When the
  // stimulus asks for a hold-off, m_tready stays low for a long stretch so
  // that the output register fills and the block stops taking bytes.
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Result monitor and activity counter for the watchdog. Both sample the
  // values that were stable before the clock edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      model.check_result(m_tdata[IndexW-1:0], m_tdata[OutDataW-1:IndexW]);
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= WatchdogLimit);
    $display("[word_substring_subsequence_filter_unit] ERROR");
    $finish;
  end

  // Flow-control phases: none, sender idle often, receiver stalling often,
  // and both idling a little.
  task automatic set_idling(input int phase);
    case (phase)
      0: begin
        sender_idle_pct = 0;
        stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 62;
        stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        stall_pct = 62;
      end
      default: begin
        sender_idle_pct = 7;
        stall_pct = 7;
      end
    endcase
  endtask

  // Offers one text byte, with a random gap first, and waits for the
  // transaction. The valid stays high on return so that back-to-back bytes
  // never drop it between transactions.
  task automatic send_byte(input bit [7:0] b, input bit eot);
    int gap;
    gap = 0;
    while ($urandom_range(99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= eot;
    @(posedge clk);
    while (!s_tready) begin
      @(posedge clk);
    end
    model.absorb_byte(b, eot);
    sent_bytes++;
  endtask

  task automatic send_text(input string s, input bit eot_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eot_at_end && (i == s.len() - 1));
    end
  endtask

  // Stops offering bytes and waits until every predicted result has left; it
  // then idles on, so that a closing byte that produced nothing has passed too.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (model.expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    model.set_register(idx, value);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input bit en, input bit md, input bit [PatLenW-1:0] len,
                           input bit [CfgDataW-1:0] lo, input bit [CfgDataW-1:0] hi);
    settle();
    cfg_write(CfgEnable, en);
    cfg_write(CfgMode, md);
    cfg_write(CfgPatternLen, len);
    cfg_write(CfgPatternLow, lo);
    cfg_write(CfgPatternHigh, hi);
  endtask

  function automatic bit [7:0] mixed_case(input bit [7:0] c);
    if (c >= "a" && c <= "z" && $urandom_range(1)) begin
      return c - 8'd32;
    end
    return c;
  endfunction

  // Pattern characters are mostly letters from a small alphabet, so that
  // random text hits them often, and now and then any byte at all.
  function automatic bit [7:0] pattern_pick();
    if ($urandom_range(9) == 0) begin
      return $urandom_range(255);
    end
    return mixed_case($urandom_range("a", "h"));
  endfunction

  // A filler letter: half the time one of the pattern's own characters.
  function automatic bit [7:0] word_letter(input int m);
    if (m > 0 && $urandom_range(1)) begin
      return mixed_case(model.pattern_char($urandom_range(m - 1)));
    end
    return mixed_case($urandom_range("a", "j"));
  endfunction

  function automatic bit [7:0] blank_byte();
    int v;
    v = $urandom_range(9, 14);
    return (v == 14) ? " " : v;
  endfunction

  // Sends one word and its separator. Most words carry the pattern (with
  // filler between its characters in subsequence mode), some miss one
  // pattern character, and the rest are random letters or raw noise bytes.
  task automatic send_random_word();
    byte unsigned w[$];
    int           m;
    int           roll;
    int           skip;
    bit           eot_word;
    m = model.active_len();
    roll = $urandom_range(99);
    skip = -1;
    repeat ($urandom_range(2)) w.push_back(word_letter(m));
    if (roll < 55 && m > 0) begin
      if ($urandom_range(3) == 0) begin
        skip = $urandom_range(m - 1);
      end
      for (int i = 0; i < m; i++) begin
        if (i != skip) begin
          w.push_back(mixed_case(model.pattern_char(i)));
        end
        if (model.mode && $urandom_range(2) == 0) begin
          w.push_back(word_letter(m));
        end
      end
    end else if (roll < 85) begin
      repeat ($urandom_range(1, 8)) w.push_back(word_letter(m));
    end else begin
      repeat ($urandom_range(1, 6)) w.push_back($urandom_range(255));
    end
    repeat ($urandom_range(2)) w.push_back(word_letter(m));
    eot_word = ($urandom_range(9) == 0);
    foreach (w[i]) begin
      send_byte(w[i], eot_word && (i == w.size() - 1));
    end
    if (!eot_word) begin
      repeat ($urandom_range(1, 2)) send_byte(blank_byte(), $urandom_range(19) == 0);
    end
  endtask

  // One random phase: a fresh register setting, then about 25 bytes of words.
  // The first segments cover the pattern length extremes, including lengths
  // above the maximum, and one segment runs with searching disabled.
  task automatic run_segment(input int seg);
    bit [PatLenW-1:0]  len;
    bit [CfgDataW-1:0] lo;
    bit [CfgDataW-1:0] hi;
    int                target;
    case (seg)
      0: len = 16;
      1: len = 0;
      2: len = 31;
      3: len = 1;
      4: len = 17;
      default: len = ($urandom_range(3) == 0) ? $urandom_range(16) : $urandom_range(1, 5);
    endcase
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    for (int i = 0; i < PatternMaxDefault && i < len; i++) begin
      if (i < 8) begin
        lo[i * 8 +: 8] = pattern_pick();
      end else begin
        hi[(i - 8) * 8 +: 8] = pattern_pick();
      end
    end
    configure(seg != 7, (seg >> 1) & 1, len, lo, hi);
    set_idling(seg % 4);
    target = sent_bytes + 25;
    while (sent_bytes < target) begin
      send_random_word();
    end
  endtask

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= CfgEnable;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tlast <= 1'b0;
    hold_req <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. Searching is off after reset, so these bytes, the
    // end-of-text flag included, must leave no trace.
    send_byte("a", 1'b0);
    send_byte("b", 1'b1);

    // Substring "CaT" given in mixed case; the text folds to match it.
    settle();
    cfg_write(CfgEnable, 1);
    cfg_write(CfgPatternLen, 3);
    cfg_write(CfgPatternLow, 64'h0000_0000_0054_6143);
    cfg_write(CfgPatternHigh, '1);
    send_text("xCATs\n", 1'b0);
    send_text("cta\v", 1'b0);
    // Byte extremes form a word that the end-of-text flag closes, then an
    // end-of-text on whitespace with no word open.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(" ", 1'b1);

    // Same pattern as a subsequence, spread over a word.
    settle();
    cfg_write(CfgMode, 1);
    send_text("xcyAzT\r", 1'b0);

    // An empty pattern matches every word.
    settle();
    cfg_write(CfgPatternLen, 0);
    send_byte("q", 1'b1);

    // Random phases under all flow-control patterns.
    for (int seg = 0; seg < 8; seg++) begin
      run_segment(seg);
    end

    // Receiver hold-off while the sender keeps offering matching words.
    configure(1'b1, 1'b0, 0, '0, '0);
    set_idling(0);
    hold_req <= 1'b1;
    repeat (10) send_text("ab ", 1'b0);

    // One long word to saturate the reported length.
    configure(1'b1, $urandom_range(1), 1, 64'h65, '0);
    set_idling(3);
    repeat (256) send_byte(mixed_case($urandom_range("a", "z")), 1'b0);
    send_byte(blank_byte(), 1'b0);

    settle();
    repeat (10) @(posedge clk);
    if (model.errors == 0 && model.expected_words.size() == 0) begin
      $display("[word_substring_subsequence_filter_unit] OK");
    end else begin
      $display("[word_substring_subsequence_filter_unit] ERROR");
    end
    $finish;
  end

endmodule
